[rtl/core/garc_pkg.sv]
// package: item types, request codes, cordic constants and arctangent table
package garc_pkg;

    localparam int COORD_W = 24;
    localparam int CORDIC_ITERS = 24;
    localparam int GUARD_BITS = 6;
    localparam int XW = 36;
    localparam int ZW = 34;
    localparam int PW = 52;
    localparam logic [14:0] INV_GAIN_HI = 15'd19898;
    localparam logic [14:0] INV_GAIN_LO = 15'd15210;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [1:0] REQ_RAPID = 2'd0;
    localparam logic [1:0] REQ_LINE = 2'd1;
    localparam logic [1:0] REQ_CW = 2'd2;
    localparam logic [1:0] REQ_CCW = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] centre_x;
        logic signed [COORD_W-1:0] centre_y;
    } garc_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic last_segment;
    } garc_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_VEC_LOAD, S_VEC_ITER, S_SWEEP, S_DIV, S_STEP, S_ROT_LOAD,
        S_ROT_ITER, S_MUL_HI, S_MUL_LO, S_GAIN, S_SAT, S_EMIT
    } garc_state_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/gcode_arc_line_interpolator.sv]
// top level: g-code line and arc interpolator with one shared cordic unit
//
//  channel | ports                     | item
//  s_      | s_valid s_ready s_item    | one motion command
//  m_      | m_valid m_ready m_item    | one drawn segment
//
//  rapid and line: done on acceptance, line plus output hand-off
//  arc: two vectoring passes, a sweep divide and ARC_SEGMENTS chords (none for a zero sweep), with one cordic iteration
//  per cycle and one shared multiplier used four times per chord
//  the next segment is computed while the previous one waits in m_item
//  reset clears position and control; s_ready is low while an item is in work
module gcode_arc_line_interpolator #(
    parameter int ARC_SEGMENTS = 60
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  garc_pkg::garc_in_t s_item,
    output logic m_valid,
    input  logic m_ready,
    output garc_pkg::garc_out_t m_item
);
    import garc_pkg::*;

    localparam int KW = $clog2(ARC_SEGMENTS + 1);
    localparam int RW = KW + 1;
    localparam int DIV_L = $clog2(ARC_SEGMENTS);
    localparam logic [KW-1:0] N_K = KW'(ARC_SEGMENTS);
    localparam logic [RW-1:0] N_R = RW'(ARC_SEGMENTS);
    localparam logic [31:0] N_W = 32'(ARC_SEGMENTS);
    localparam logic [32:0] DIV_M = 33'((64'd1 << (32 + DIV_L)) / 64'(ARC_SEGMENTS));
    localparam logic signed [COORD_W:0] SAT_HI = (COORD_W+1)'((1 << (COORD_W-1)) - 1);
    localparam logic signed [COORD_W:0] SAT_LO = -(COORD_W+1)'(1 << (COORD_W-1));

    garc_state_t state_reg, state_next;
    garc_in_t req_reg, req_next;
    garc_out_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic signed [COORD_W-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic signed [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic signed [COORD_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic signed [COORD_W:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [COORD_W:0] tdx_reg, tdx_next, tdy_reg, tdy_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [4:0] it_reg, it_next;
    logic sel_reg, sel_next, zero_reg, zero_next, axis_reg, axis_next;
    logic [31:0] ac_reg, ac_next, at_reg, at_next, sweep_reg, sweep_next;
    logic [31:0] qs_reg, qs_next, q_reg, q_next, ang_reg, ang_next;
    logic [RW-1:0] rs_reg, rs_next, r_reg, r_next;
    logic [64:0] dp_reg, dp_next;
    logic [1:0] dc_reg, dc_next;
    logic [KW-1:0] k_reg, k_next;
    logic signed [PW-1:0] phi_reg, phi_next, plo_reg, plo_next;
    logic signed [ZW-1:0] rr_reg, rr_next;

    logic accept, out_free, dir_up, it_last;
    logic signed [XW-1:0] xs, ys, vx0, vy0, opnd;
    logic signed [COORD_W:0] vdx, vdy;
    logic [31:0] atan_v, ang_adj, sweep_calc;
    logic [RW-1:0] r_sum;
    logic [16:0] dm_op;
    logic [48:0] dmul;
    logic [31:0] q_est, r_est;
    logic signed [PW-1:0] mul_res, t_sum, rnd;
    logic signed [COORD_W+10:0] sum_c;
    logic signed [COORD_W-1:0] sat_v;

    assign accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_item = out_reg;
    assign it_last = (it_reg == 5'(CORDIC_ITERS - 1));

    // shared cordic step
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;
    assign atan_v = atan_lut(it_reg);
    assign dir_up = (state_reg == S_VEC_ITER) ? !(y_reg > 0) : (z_reg >= 0);

    assign vdx = sel_reg ? tdx_reg : dx_reg;
    assign vdy = sel_reg ? tdy_reg : dy_reg;
    assign vx0 = XW'(vdx) <<< GUARD_BITS;
    assign vy0 = XW'(vdy) <<< GUARD_BITS;
    assign ang_adj = ang_reg + QUARTER_TURN;

    assign sweep_calc = (req_reg.req_type == REQ_CCW) ? at_reg - ac_reg : ac_reg - at_reg;
    assign r_sum = r_reg + rs_reg;

    // sweep step by reciprocal multiply, one quotient fix-up
    assign dm_op = (dc_reg == 2'd0) ? DIV_M[32:16] : {1'b0, DIV_M[15:0]};
    assign dmul = sweep_reg * dm_op;
    assign q_est = 32'(dp_reg >> (32 + DIV_L));
    assign r_est = sweep_reg - q_est * N_W;

    // shared multiplier
    assign opnd = axis_reg ? y_reg : x_reg;
    assign mul_res = opnd * $signed({1'b0, (state_reg == S_MUL_HI) ? INV_GAIN_HI
                                                                    : INV_GAIN_LO});
    assign t_sum = phi_reg + (plo_reg >>> 15);
    assign rnd = (t_sum + (PW'(1) <<< (14 + GUARD_BITS))) >>> (15 + GUARD_BITS);
    assign sum_c = (COORD_W+11)'(axis_reg ? req_reg.centre_y : req_reg.centre_x)
                 + (COORD_W+11)'(rr_reg);
    assign sat_v = (sum_c > (COORD_W+11)'(SAT_HI)) ? SAT_HI[COORD_W-1:0]
                 : (sum_c < (COORD_W+11)'(SAT_LO)) ? SAT_LO[COORD_W-1:0]
                 : sum_c[COORD_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_item.req_type == REQ_CW || s_item.req_type == REQ_CCW)) begin
                    state_next = S_VEC_LOAD;
                end
            end
            S_VEC_LOAD: state_next = S_VEC_ITER;
            S_VEC_ITER: begin
                if (it_last) begin
                    state_next = sel_reg ? S_SWEEP : S_VEC_LOAD;
                end
            end
            S_SWEEP: state_next = (sweep_calc == 32'd0) ? S_IDLE : S_DIV;
            S_DIV: begin
                if (dc_reg == 2'd2) begin
                    state_next = S_STEP;
                end
            end
            S_STEP: state_next = S_ROT_LOAD;
            S_ROT_LOAD: state_next = S_ROT_ITER;
            S_ROT_ITER: begin
                if (it_last) begin
                    state_next = S_MUL_HI;
                end
            end
            S_MUL_HI: state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_GAIN;
            S_GAIN: state_next = S_SAT;
            S_SAT: state_next = axis_reg ? S_EMIT : S_MUL_HI;
            S_EMIT: begin
                if (out_free) begin
                    state_next = (k_reg == N_K) ? S_IDLE : S_STEP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready = (state_reg == S_IDLE) && !m_valid_reg;
        req_next = req_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        px_next = px_reg;
        py_next = py_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        tdx_next = tdx_reg;
        tdy_next = tdy_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        it_next = it_reg;
        sel_next = sel_reg;
        zero_next = zero_reg;
        axis_next = axis_reg;
        ac_next = ac_reg;
        at_next = at_reg;
        sweep_next = sweep_reg;
        qs_next = qs_reg;
        q_next = q_reg;
        ang_next = ang_reg;
        rs_next = rs_reg;
        r_next = r_reg;
        dp_next = dp_reg;
        dc_next = dc_reg;
        k_next = k_reg;
        phi_next = phi_reg;
        plo_next = plo_reg;
        rr_next = rr_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next = s_item;
                    dx_next = (COORD_W+1)'(pos_x_reg) - (COORD_W+1)'(s_item.centre_x);
                    dy_next = (COORD_W+1)'(pos_y_reg) - (COORD_W+1)'(s_item.centre_y);
                    tdx_next = (COORD_W+1)'(s_item.target_x) - (COORD_W+1)'(s_item.centre_x);
                    tdy_next = (COORD_W+1)'(s_item.target_y) - (COORD_W+1)'(s_item.centre_y);
                    sel_next = 1'b0;
                    if (s_item.req_type == REQ_LINE) begin
                        out_next = '{pos_x_reg, pos_y_reg, s_item.target_x,
                                     s_item.target_y, 1'b1};
                        m_valid_next = 1'b1;
                    end
                    if (s_item.req_type == REQ_LINE || s_item.req_type == REQ_RAPID) begin
                        pos_x_next = s_item.target_x;
                        pos_y_next = s_item.target_y;
                    end
                end
            end
            S_VEC_LOAD: begin
                zero_next = (vdx == '0) && (vdy == '0);
                it_next = '0;
                if (vx0 < 0) begin
                    x_next = -vx0;
                    y_next = -vy0;
                    z_next = ZW'(HALF_TURN);
                end else begin
                    x_next = vx0;
                    y_next = vy0;
                    z_next = '0;
                end
            end
            S_VEC_ITER, S_ROT_ITER: begin
                if (dir_up) begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ZW'(atan_v);
                end else begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ZW'(atan_v);
                end
                it_next = it_reg + 5'd1;
                if (state_reg == S_VEC_ITER && it_last) begin
                    sel_next = 1'b1;
                    if (sel_reg) begin
                        at_next = zero_reg ? 32'd0 : z_next[31:0];
                    end else begin
                        ac_next = zero_reg ? 32'd0 : z_next[31:0];
                    end
                end
                if (state_reg == S_ROT_ITER && it_last) begin
                    axis_next = 1'b0;
                end
            end
            S_SWEEP: begin
                sweep_next = sweep_calc;
                dc_next = '0;
                if (sweep_calc == 32'd0) begin
                    pos_x_next = req_reg.target_x;
                    pos_y_next = req_reg.target_y;
                end
            end
            S_DIV: begin
                dc_next = dc_reg + 2'd1;
                if (dc_reg == 2'd0) begin
                    dp_next = {dmul, 16'd0};
                end else if (dc_reg == 2'd1) begin
                    dp_next = dp_reg + 65'(dmul);
                end else begin
                    if (r_est >= N_W) begin
                        qs_next = q_est + 32'd1;
                        rs_next = RW'(r_est - N_W);
                    end else begin
                        qs_next = q_est;
                        rs_next = RW'(r_est);
                    end
                    q_next = '0;
                    r_next = '0;
                    k_next = '0;
                    px_next = pos_x_reg;
                    py_next = pos_y_reg;
                end
            end
            S_STEP: begin
                k_next = k_reg + KW'(1);
                if (r_sum >= N_R) begin
                    r_next = r_sum - N_R;
                    q_next = q_reg + qs_reg + 32'd1;
                end else begin
                    r_next = r_sum;
                    q_next = q_reg + qs_reg;
                end
                ang_next = (req_reg.req_type == REQ_CCW) ? q_next : 32'd0 - q_next;
            end
            S_ROT_LOAD: begin
                it_next = '0;
                x_next = XW'(dx_reg) <<< GUARD_BITS;
                y_next = XW'(dy_reg) <<< GUARD_BITS;
                z_next = ZW'($signed(ang_reg));
                if (ang_adj >= HALF_TURN) begin
                    x_next = -(XW'(dx_reg) <<< GUARD_BITS);
                    y_next = -(XW'(dy_reg) <<< GUARD_BITS);
                    z_next = ZW'($signed(ang_reg + HALF_TURN));
                end
            end
            S_MUL_HI: phi_next = mul_res;
            S_MUL_LO: plo_next = mul_res;
            S_GAIN: rr_next = rnd[ZW-1:0];
            S_SAT: begin
                axis_next = 1'b1;
                if (axis_reg) begin
                    ny_next = sat_v;
                end else begin
                    nx_next = sat_v;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_next = '{px_reg, py_reg, nx_reg, ny_reg, k_reg == N_K};
                    m_valid_next = 1'b1;
                    px_next = nx_reg;
                    py_next = ny_reg;
                    if (k_reg == N_K) begin
                        pos_x_next = req_reg.target_x;
                        pos_y_next = req_reg.target_y;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        out_reg <= out_next;
        px_reg <= px_next;
        py_reg <= py_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        tdx_reg <= tdx_next;
        tdy_reg <= tdy_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        it_reg <= it_next;
        sel_reg <= sel_next;
        zero_reg <= zero_next;
        axis_reg <= axis_next;
        ac_reg <= ac_next;
        at_reg <= at_next;
        sweep_reg <= sweep_next;
        qs_reg <= qs_next;
        q_reg <= q_next;
        ang_reg <= ang_next;
        rs_reg <= rs_next;
        r_reg <= r_next;
        dp_reg <= dp_next;
        dc_reg <= dc_next;
        k_reg <= k_next;
        phi_reg <= phi_next;
        plo_reg <= plo_next;
        rr_reg <= rr_next;
    end

    a_accept_free: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !m_valid_reg)
        else $error("item accepted while a segment is pending");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_STEP |-> (k_reg < N_K) && (r_reg < N_R))
        else $error("chord counter or angle remainder out of range");

    a_zero_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP && sweep_calc == 32'd0) |=> state_reg == S_IDLE)
        else $error("zero sweep did not finish the arc");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free && k_reg == N_K) |=>
            (m_valid_reg && m_item.last_segment && state_reg == S_IDLE))
        else $error("final chord not flagged as last");

endmodule
